/* rtl/core/stwc_pkg.sv */
package stwc_pkg;

	localparam int MAX_TRAIL_DEF   = 32;
	localparam int MAX_DECAY_DEF   = 63;
	localparam int SAMPLE_BITS_DEF = 24;
	localparam int INDEX_BITS_DEF  = 20;

	localparam int REG_IDX_BITS = 3;

	localparam logic [REG_IDX_BITS-1:0] REG_THRESHOLD = 3'd0;
	localparam logic [REG_IDX_BITS-1:0] REG_TRAIL     = 3'd1;
	localparam logic [REG_IDX_BITS-1:0] REG_DECAY     = 3'd2;
	localparam logic [REG_IDX_BITS-1:0] REG_START     = 3'd3;
	localparam logic [REG_IDX_BITS-1:0] REG_LENGTH    = 3'd4;

	localparam int RST_THRESHOLD = 10000;
	localparam int RST_TRAIL     = 5;
	localparam int RST_DECAY     = 20;
	localparam int RST_START     = 0;

	typedef enum logic [1:0] {
		ST_RUN   = 2'b01,
		ST_BURST = 2'b10
	} ctrl_state_t;

	typedef enum logic [2:0] {
		PH_SEARCH  = 3'b001,
		PH_CAPTURE = 3'b010,
		PH_DONE    = 3'b100
	} phase_t;

endpackage

/* rtl/core/slope_trigger_window_capture.sv */
// Slope-triggered window capture. Each accepted item is one signed sample, with
// tuser set on the first sample of a record. While searching, a sample whose
// first difference exceeds the threshold, at or after search_start plus
// trail_count and with its window clear of the record's last sample, triggers: the block
// then sends the trail_count samples before it, the trigger sample itself and,
// one per following item, the rest of decay_count samples; tlast marks the
// final result of the record, and a record that reaches its length without a
// trigger ends in a single not-found result. Ordinary samples are taken at one
// per clock cycle while the output is free. At a trigger the buffered samples
// are read out of the shift chain of trail cells one per cycle while the output
// is free, and the input waits until the last is sent. No clearing pass follows reset.
module slope_trigger_window_capture
	#(
	parameter int MAX_TRAIL   = stwc_pkg::MAX_TRAIL_DEF,
	parameter int MAX_DECAY   = stwc_pkg::MAX_DECAY_DEF,
	parameter int SAMPLE_BITS = stwc_pkg::SAMPLE_BITS_DEF,
	parameter int INDEX_BITS  = stwc_pkg::INDEX_BITS_DEF,
	localparam int THR_BITS   = SAMPLE_BITS + 1,
	localparam int APB_W      = (THR_BITS > 32) ? 64 : 32,
	localparam int ADDR_LSB   = (APB_W == 64) ? 3 : 2,
	localparam int ADDR_BITS  = ADDR_LSB + stwc_pkg::REG_IDX_BITS,
	localparam int OFF_BITS   = $clog2(MAX_TRAIL + MAX_DECAY),
	localparam int IN_BITS    = ((SAMPLE_BITS + 7) / 8) * 8,
	localparam int OUT_BITS   = ((SAMPLE_BITS + OFF_BITS + INDEX_BITS + 7) / 8) * 8
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [ADDR_BITS-1:0] paddr,
	input  logic [APB_W-1:0]     pwdata,
	output logic [APB_W-1:0]     prdata,
	output logic                 pready,
	input  logic                 s_axis_tvalid,
	output logic                 s_axis_tready,
	input  logic [IN_BITS-1:0]   s_axis_tdata,  // sample
	input  logic                 s_axis_tuser,  // first
	output logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	output logic [OUT_BITS-1:0]  m_axis_tdata,  // window_sample, window_offset, spike_position
	output logic                 m_axis_tuser,  // found
	output logic                 m_axis_tlast
);

	import stwc_pkg::*;

	localparam int SB         = SAMPLE_BITS;
	localparam int IB         = INDEX_BITS;
	localparam int CB         = INDEX_BITS + 1;
	localparam int TRL_BITS   = $clog2(MAX_TRAIL + 1);
	localparam int DEC_BITS   = $clog2(MAX_DECAY + 1);
	localparam int CHAIN_LEN  = MAX_TRAIL + 1;

	// Configuration registers
	logic [THR_BITS-1:0] thr_q;
	logic [TRL_BITS-1:0] trail_q;
	logic [DEC_BITS-1:0] decay_q;
	logic [IB-1:0]       start_q;
	logic [CB-1:0]       len_q;

	logic [REG_IDX_BITS-1:0] reg_idx;
	logic                    cfg_wr;

	assign reg_idx = paddr[ADDR_BITS-1:ADDR_LSB];
	assign cfg_wr  = psel & penable & pwrite & pready;
	assign pready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q   <= THR_BITS'(RST_THRESHOLD);
			trail_q <= TRL_BITS'(RST_TRAIL);
			decay_q <= DEC_BITS'(RST_DECAY);
			start_q <= IB'(RST_START);
			len_q   <= CB'(1) << IB;
		end else if (cfg_wr) begin
			unique case (reg_idx)
				REG_THRESHOLD: thr_q   <= THR_BITS'(pwdata);
				REG_TRAIL:     trail_q <= pwdata[TRL_BITS-1:0];
				REG_DECAY:     decay_q <= pwdata[DEC_BITS-1:0];
				REG_START:     start_q <= pwdata[IB-1:0];
				REG_LENGTH:    len_q   <= pwdata[CB-1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_THRESHOLD: prdata = APB_W'(thr_q);
			REG_TRAIL:     prdata = APB_W'(trail_q);
			REG_DECAY:     prdata = APB_W'(decay_q);
			REG_START:     prdata = APB_W'(start_q);
			REG_LENGTH:    prdata = APB_W'(len_q);
			default:       prdata = '0;
		endcase
	end

	// Effective settings
	logic [TRL_BITS-1:0] t_eff;
	logic [DEC_BITS-1:0] d_eff;
	logic [CB-1:0]       len_eff;

	assign t_eff   = (trail_q > TRL_BITS'(MAX_TRAIL)) ? TRL_BITS'(MAX_TRAIL) : trail_q;
	assign d_eff   = (decay_q == '0) ? DEC_BITS'(1) :
	                 (decay_q > DEC_BITS'(MAX_DECAY)) ? DEC_BITS'(MAX_DECAY) : decay_q;
	assign len_eff = (len_q == '0) ? CB'(1) : len_q;

	// Control state
	ctrl_state_t         state_q;
	phase_t              phase_q;
	logic [CB-1:0]       idx_q;
	logic [SB-1:0]       prev_q;
	logic [DEC_BITS-1:0] decay_left_q;
	logic [TRL_BITS-1:0] rd_q;
	logic                out_valid_q;

	logic [IB-1:0]       trig_pos_q;
	logic                burst_last_q;
	logic [OFF_BITS-1:0] off_cnt_q;

	logic [SB-1:0]       out_sample_q;
	logic [OFF_BITS-1:0] out_off_q;
	logic [IB-1:0]       out_pos_q;
	logic                out_found_q;
	logic                out_last_q;

	logic          out_free;
	logic          in_acc;
	logic          first_in;
	logic [SB-1:0] sample_in;
	logic [CB-1:0] idx_e;
	logic [SB-1:0] prev_e;
	phase_t        phase_e;

	logic [THR_BITS-1:0] diff;
	logic                diff_gt;
	logic                start_ok;
	logic                fit_ok;
	logic                end_hit;
	logic                trig;
	logic                not_found;
	logic                cap;
	logic                burst_emit;
	logic [SB-1:0]       chain_out;

	assign out_free      = !out_valid_q || m_axis_tready;
	assign s_axis_tready = (state_q == ST_RUN) && out_free;
	assign in_acc        = s_axis_tvalid && s_axis_tready;
	assign first_in      = s_axis_tuser;
	assign sample_in     = s_axis_tdata[SB-1:0];

	assign idx_e   = first_in ? '0 : idx_q;
	assign prev_e  = first_in ? '0 : prev_q;
	assign phase_e = first_in ? PH_SEARCH : phase_q;

	assign diff     = {sample_in[SB-1], sample_in} - {prev_e[SB-1], prev_e};
	assign diff_gt  = $signed(diff) > $signed(thr_q);
	assign start_ok = idx_e >= (CB'(start_q) + CB'(t_eff));
	assign fit_ok   = ((CB+1)'(idx_e) + (CB+1)'(d_eff)) < (CB+1)'(len_eff);
	assign end_hit  = ((CB+1)'(idx_e) + (CB+1)'(1)) >= (CB+1)'(len_eff);

	assign trig       = (phase_e == PH_SEARCH) && start_ok && fit_ok && diff_gt;
	assign not_found  = (phase_e == PH_SEARCH) && !trig && end_hit;
	assign cap        = (phase_e == PH_CAPTURE);
	assign burst_emit = (state_q == ST_BURST) && out_free;

	stwc_chain #(
		.W        (SB),
		.DEPTH    (CHAIN_LEN),
		.IDX_BITS (TRL_BITS)
	) u_chain (
		.clk    (clk),
		.shift  (in_acc),
		.din    (sample_in),
		.rd_idx (rd_q),
		.dout   (chain_out)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_RUN;
			phase_q      <= PH_SEARCH;
			idx_q        <= '0;
			prev_q       <= '0;
			decay_left_q <= '0;
			rd_q         <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (burst_emit || (in_acc && (cap || not_found))) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end

			if (burst_emit) begin
				if (rd_q == '0) begin
					state_q <= ST_RUN;
				end else begin
					rd_q <= rd_q - TRL_BITS'(1);
				end
			end

			if (in_acc) begin
				prev_q       <= sample_in;
				idx_q        <= (idx_e == '1) ? idx_e : idx_e + CB'(1);
				phase_q      <= phase_e;
				decay_left_q <= first_in ? '0 : decay_left_q;
				if (trig) begin
					state_q      <= ST_BURST;
					rd_q         <= t_eff;
					decay_left_q <= d_eff - DEC_BITS'(1);
					phase_q      <= (d_eff == DEC_BITS'(1)) ? PH_DONE : PH_CAPTURE;
				end else if (not_found) begin
					phase_q <= PH_DONE;
				end else if (cap) begin
					decay_left_q <= decay_left_q - DEC_BITS'(1);
					if (decay_left_q == DEC_BITS'(1)) begin
						phase_q <= PH_DONE;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc && trig) begin
			trig_pos_q   <= idx_e[IB-1:0];
			burst_last_q <= (d_eff == DEC_BITS'(1));
			off_cnt_q    <= '0;
		end else if (burst_emit || (in_acc && cap)) begin
			off_cnt_q <= off_cnt_q + OFF_BITS'(1);
		end

		if (burst_emit) begin
			out_sample_q <= chain_out;
			out_off_q    <= off_cnt_q;
			out_pos_q    <= trig_pos_q;
			out_found_q  <= 1'b1;
			out_last_q   <= (rd_q == '0) && burst_last_q;
		end else if (in_acc && cap) begin
			out_sample_q <= sample_in;
			out_off_q    <= off_cnt_q;
			out_pos_q    <= trig_pos_q;
			out_found_q  <= 1'b1;
			out_last_q   <= (decay_left_q == DEC_BITS'(1));
		end else if (in_acc && not_found) begin
			out_sample_q <= '0;
			out_off_q    <= '0;
			out_pos_q    <= '0;
			out_found_q  <= 1'b0;
			out_last_q   <= 1'b1;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = OUT_BITS'({out_pos_q, out_off_q, out_sample_q});
	assign m_axis_tuser  = out_found_q;
	assign m_axis_tlast  = out_last_q;

endmodule

/* rtl/core/stwc_cell.sv */
module stwc_cell #(
	parameter int W = 24
) (
	input  logic         clk,
	input  logic         shift,
	input  logic [W-1:0] d,
	output logic [W-1:0] q
);

	logic [W-1:0] data_q;

	always_ff @(posedge clk) begin
		if (shift) begin
			data_q <= d;
		end
	end

	assign q = data_q;

endmodule

/* rtl/core/stwc_chain.sv */
module stwc_chain #(
	parameter int W        = 24,
	parameter int DEPTH    = 33,
	parameter int IDX_BITS = 6
) (
	input  logic                clk,
	input  logic                shift,
	input  logic [W-1:0]        din,
	input  logic [IDX_BITS-1:0] rd_idx,
	output logic [W-1:0]        dout
);

	// Cell 0 holds the newest sample; each shift moves every sample one cell on.
	logic [W-1:0] tap [DEPTH];

	genvar i;
	generate
		for (i = 0; i < DEPTH; i++) begin : g_cell
			if (i == 0) begin : g_head
				stwc_cell #(.W(W)) u_cell (
					.clk   (clk),
					.shift (shift),
					.d     (din),
					.q     (tap[i])
				);
			end else begin : g_body
				stwc_cell #(.W(W)) u_cell (
					.clk   (clk),
					.shift (shift),
					.d     (tap[i-1]),
					.q     (tap[i])
				);
			end
		end
	endgenerate

	always_comb begin
		dout = '0;
		for (int k = 0; k < DEPTH; k++) begin
			if (rd_idx == IDX_BITS'(k)) begin
				dout = tap[k];
			end
		end
	end

endmodule

/* sim/tb_slope_trigger_window_capture.sv */
`timescale 1ns / 100ps

module tb_slope_trigger_window_capture;
	import stwc_pkg::*;

	localparam int     HOLD_CYCLES = 300;
	localparam int     TAIL_CYCLES = 48;
	localparam int     STALL_LIMIT = 4000;
	localparam longint IDX_TOP     = (64'd1 << 21) - 1;

	typedef struct packed {
		logic [23:0] smp;
		logic        head;
	} sample_item_t;

	typedef struct packed {
		logic [23:0] smp;
		logic [6:0]  off;
		logic [19:0] pos;
		logic        found;
		logic        fin;
	} window_res_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [4:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [23:0] s_axis_tdata = '0;  // sample
	logic        s_axis_tuser = 1'b0;  // first
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [55:0] m_axis_tdata;  // window_sample, window_offset, spike_position
	logic        m_axis_tuser;  // found
	logic        m_axis_tlast;

	slope_trigger_window_capture uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	logic signed [24:0] cfg_thr   = 25'(RST_THRESHOLD);
	logic [5:0]         cfg_trail = 6'(RST_TRAIL);
	logic [5:0]         cfg_decay = 6'(RST_DECAY);
	logic [19:0]        cfg_start = 20'(RST_START);
	logic [20:0]        cfg_len   = 21'd1048576;

	logic [23:0] m_ring [MAX_TRAIL_DEF] = '{default: '0};
	logic [23:0] m_prev = '0;
	longint      m_idx = 0;
	phase_t      m_phase = PH_SEARCH;
	longint      m_left = 0;
	int          m_wpos = 0;
	longint      m_t_pos = 0;
	longint      m_t_trail = 0;
	longint      m_t_decay = 0;

	sample_item_t pending [$];
	window_res_t  capture_due [$];

	int tx_gap = 0;
	int rx_stall = 0;
	int hold_asked = 0;
	int hold_served = 0;
	bit tx_busy = 1'b1;
	bit rx_random = 1'b1;
	int quiet = 0;

	int errors = 0;
	int n_in = 0;
	int n_records = 0;
	int n_results = 0;
	int n_windows = 0;
	int n_missing = 0;

	sample_item_t nxt;
	window_res_t  exp_r;
	window_res_t  got_r;
	int           rx_roll;

	task automatic due(input logic [23:0] smp, input longint off, input longint pos,
			input bit found, input bit fin);
		window_res_t r;
		r.smp   = smp;
		r.off   = off[6:0];
		r.pos   = pos[19:0];
		r.found = found;
		r.fin   = fin;
		capture_due.push_back(r);
	endtask

	task automatic predict_capture(input logic [23:0] smp, input logic head);
		longint len, t, d, diff, k;
		if (head) begin
			m_idx   = 0;
			m_prev  = '0;
			m_phase = PH_SEARCH;
			m_left  = 0;
			m_wpos  = 0;
		end
		len = (cfg_len == 0) ? 1 : longint'(cfg_len);
		t = (cfg_trail > MAX_TRAIL_DEF) ? MAX_TRAIL_DEF : longint'(cfg_trail);
		d = (cfg_decay == 0) ? 1 : longint'(cfg_decay);
		if (d > MAX_DECAY_DEF)
			d = MAX_DECAY_DEF;
		case (m_phase)
			PH_SEARCH: begin
				diff = longint'($signed(smp)) - longint'($signed(m_prev));
				if (m_idx >= longint'(cfg_start) + t && m_idx + d < len
						&& diff > longint'(cfg_thr)) begin
					for (k = 0; k < t; k++)
						due(m_ring[(m_wpos + MAX_TRAIL_DEF - t + k) % MAX_TRAIL_DEF],
							k, m_idx, 1'b1, 1'b0);
					due(smp, t, m_idx, 1'b1, d == 1);
					m_t_pos   = m_idx;
					m_t_trail = t;
					m_t_decay = d;
					m_left    = d - 1;
					if (m_left == 0)
						m_phase = PH_DONE;
					else
						m_phase = PH_CAPTURE;
				end else if (m_idx + 1 >= len) begin
					due('0, 0, 0, 1'b0, 1'b1);
					m_phase = PH_DONE;
				end
			end
			PH_CAPTURE: begin
				m_left = m_left - 1;
				due(smp, m_t_trail + m_t_decay - m_left - 1, m_t_pos, 1'b1, m_left == 0);
				if (m_left == 0)
					m_phase = PH_DONE;
			end
			default: ;
		endcase
		m_ring[m_wpos] = smp;
		m_wpos = (m_wpos + 1) % MAX_TRAIL_DEF;
		m_prev = smp;
		if (m_idx < IDX_TOP)
			m_idx++;
	endtask

	function automatic int pick_gap(input bit busy);
		int r;
		if (!busy)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata <= '0;
			s_axis_tuser <= 1'b0;
			tx_gap <= 0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				predict_capture(s_axis_tdata, s_axis_tuser);
				n_in++;
				if (s_axis_tuser)
					n_records++;
			end
			if (!s_axis_tvalid || s_axis_tready) begin
				if (tx_gap != 0) begin
					s_axis_tvalid <= 1'b0;
					tx_gap <= tx_gap - 1;
				end else if (pending.size() != 0) begin
					nxt = pending.pop_front();
					s_axis_tdata <= nxt.smp;
					s_axis_tuser <= nxt.head;
					s_axis_tvalid <= 1'b1;
					tx_gap <= pick_gap(tx_busy);
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	task automatic flag_result(input string why, input window_res_t e, input window_res_t g);
		errors++;
		if (errors <= 10) begin
			$display("%0t %s: expected sample %0d offset %0d position %0d found %b last %b",
				$time, why, $signed(e.smp), e.off, e.pos, e.found, e.fin);
			$display("%0t %s: actual   sample %0d offset %0d position %0d found %b last %b",
				$time, why, $signed(g.smp), g.off, g.pos, g.found, g.fin);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			rx_stall <= 0;
			hold_served <= 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				got_r.smp   = m_axis_tdata[23:0];
				got_r.off   = m_axis_tdata[30:24];
				got_r.pos   = m_axis_tdata[50:31];
				got_r.found = m_axis_tuser;
				got_r.fin   = m_axis_tlast;
				n_results++;
				if (!got_r.found)
					n_missing++;
				else if (got_r.fin)
					n_windows++;
				if (capture_due.size() == 0) begin
					flag_result("unexpected result", '0, got_r);
				end else begin
					exp_r = capture_due.pop_front();
					if (exp_r != got_r)
						flag_result("result mismatch", exp_r, got_r);
				end
			end
			if (hold_served != hold_asked) begin
				hold_served <= hold_asked;
				rx_stall <= HOLD_CYCLES;
				m_axis_tready <= 1'b0;
			end else if (rx_stall != 0) begin
				rx_stall <= rx_stall - 1;
				m_axis_tready <= 1'b0;
			end else if (!rx_random) begin
				m_axis_tready <= 1'b1;
			end else begin
				rx_roll = $urandom_range(0, 99);
				if (rx_roll < 3) begin
					rx_stall <= $urandom_range(8, 40);
					m_axis_tready <= 1'b0;
				end else begin
					m_axis_tready <= (rx_roll >= 25);
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
				quiet <= 0;
			else
				quiet <= quiet + 1;
			if (quiet >= STALL_LIMIT) begin
				$display("Watchdog: no item moved for %0d cycles, %0d results outstanding",
					quiet, capture_due.size());
				$display("Mismatches found");
				$finish;
			end
		end
	end

	task automatic write_reg(input logic [2:0] idx, input longint value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value[31:0];
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_THRESHOLD: cfg_thr = value[24:0];
			REG_TRAIL:     cfg_trail = value[5:0];
			REG_DECAY:     cfg_decay = value[5:0];
			REG_START:     cfg_start = value[19:0];
			REG_LENGTH:    cfg_len = value[20:0];
			default: ;
		endcase
	endtask

	task automatic write_all(input longint thr, input longint tr, input longint dc,
			input longint st, input longint ln);
		write_reg(REG_THRESHOLD, thr);
		write_reg(REG_TRAIL, tr);
		write_reg(REG_DECAY, dc);
		write_reg(REG_START, st);
		write_reg(REG_LENGTH, ln);
	endtask

	function automatic longint clip24(input longint v);
		if (v > 8388607)
			return 8388607;
		if (v < -8388608)
			return -8388608;
		return v;
	endfunction

	function automatic void push_item(input longint v, input bit head);
		sample_item_t it;
		it.smp  = 24'(clip24(v));
		it.head = head;
		pending.push_back(it);
	endfunction

	function automatic longint any_sample();
		return longint'($urandom_range(0, 24'hFFFFFF)) - 8388608;
	endfunction

	// A record starts with the first flag, keeps mostly to a band of +/- noise with
	// some random full-scale samples, and carries one step of lift somewhere in [lo, hi].
	task automatic push_record(input int len, input int lo, input int hi,
			input int noise, input int lift);
		longint prev, v;
		int i, spike_at;
		prev = 0;
		spike_at = $urandom_range(lo, hi);
		for (i = 0; i < len; i++) begin
			if (i == spike_at)
				v = prev + lift;
			else if ($urandom_range(0, 19) == 0)
				v = any_sample();
			else
				v = longint'($urandom_range(0, 2 * noise)) - noise;
			v = clip24(v);
			push_item(v, i == 0);
			prev = v;
		end
	endtask

	task automatic settle();
		do
			@(negedge clk);
		while (pending.size() != 0 || s_axis_tvalid || capture_due.size() != 0);
		repeat (TAIL_CYCLES) @(negedge clk);
	endtask

	task automatic random_phase(input int budget);
		int thr, tr, dc, st, ln, te, de, used, n, r, noise, lift, lo;
		thr = ($urandom_range(0, 9) == 0) ? -int'($urandom_range(0, 50000))
			: int'($urandom_range(200, 300000));
		tr = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 40) : $urandom_range(0, 8);
		dc = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 63) : $urandom_range(0, 12);
		st = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 30) : 0;
		te = (tr > MAX_TRAIL_DEF) ? MAX_TRAIL_DEF : tr;
		de = (dc == 0) ? 1 : dc;
		ln = st + te + de + $urandom_range(0, 24);
		if ($urandom_range(0, 5) == 0)
			ln = $urandom_range(1, 20);
		write_all(thr, tr, dc, st, ln);
		noise = (thr > 400) ? thr / 4 : 100;
		lift = ((thr > 0) ? thr : 0) + $urandom_range(1, 3000);
		used = 0;
		while (used < budget) begin
			r = $urandom_range(0, 9);
			lo = (st + te < ln && $urandom_range(0, 2) != 0) ? st + te : 0;
			if (r < 7) begin
				push_record(ln, lo, ln - 1, noise, lift);
				used += ln;
			end else if (r < 9) begin
				n = $urandom_range(1, ln);
				push_record(n, 0, n - 1, noise, lift);
				used += n;
			end else begin
				n = $urandom_range(1, 5);
				repeat (n) push_item(any_sample(), 1'($urandom_range(0, 1)));
				used += n;
			end
		end
		settle();
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		write_all(100, 2, 2, 0, 6);
		// Samples before any first flag count as the start of a record.
		push_item(3, 0);
		push_item(4, 0);
		push_item(0, 1);
		push_item(10, 0);
		push_item(20, 0);
		push_item(400, 0);
		push_item(410, 0);
		push_item(420, 0);
		// The step comes too late for its window to fit, so the record ends unfound.
		push_item(0, 1);
		push_item(0, 0);
		push_item(0, 0);
		push_item(0, 0);
		push_item(900, 0);
		push_item(0, 0);
		push_item(77, 0);
		push_item(-77, 0);
		// A new first flag abandons the window that has just opened.
		push_item(0, 1);
		push_item(0, 0);
		push_item(500, 0);
		push_item(8388607, 1);
		push_item(-8388608, 0);
		push_item(8388607, 0);
		push_item(-1, 0);
		push_item(5, 0);
		push_item(6, 0);
		settle();

		repeat (3) random_phase(30);

		tx_busy = 1'b0;
		rx_random = 1'b0;
		write_all(-16777216, 0, 0, 0, 5);
		repeat (8) push_record(5, 0, 4, 1000000, 0);
		settle();

		tx_busy = 1'b1;
		rx_random = 1'b1;
		write_all(16777215, 63, 63, 1048575, 0);
		repeat (20) push_item(any_sample(), 1'($urandom_range(0, 1)));
		settle();

		// The receiver holds off while a full-size window builds up behind it.
		tx_busy = 1'b0;
		write_all(30000, 32, 63, 0, 1048576);
		hold_asked++;
		push_record(96, 32, 32, 7500, 40000);
		push_record(40, 0, 39, 7500, 40000);
		settle();
		tx_busy = 1'b1;

		repeat (3) random_phase(30);

		// Shortening the record while searching past the new end.
		write_all(16777215, 0, 1, 0, 40);
		push_record(20, 0, 19, 1000, 0);
		settle();
		write_reg(REG_LENGTH, 10);
		repeat (3) push_item(any_sample(), 0);
		settle();

		// Register changes inside an open window must not disturb it.
		write_all(1000, 3, 10, 0, 40);
		push_item(0, 1);
		repeat (5) push_item(longint'($urandom_range(0, 200)), 0);
		push_item(5000, 0);
		push_item(11, 0);
		push_item(12, 0);
		settle();
		write_reg(REG_TRAIL, 20);
		write_reg(REG_DECAY, 2);
		repeat (10) push_item(any_sample(), 0);
		settle();

		$display("Sent %0d samples in %0d flagged records; checked %0d results,", n_in,
			n_records, n_results);
		$display("%0d completed windows and %0d records without a trigger.", n_windows,
			n_missing);
		if (errors == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

/* sim.f */
rtl/core/stwc_pkg.sv
rtl/core/stwc_cell.sv
rtl/core/stwc_chain.sv
rtl/core/slope_trigger_window_capture.sv
sim/tb_slope_trigger_window_capture.sv
